// ----- hw/rtl/anl_pkg.sv -----
// ----------------------------------------------------------------------------
// anl_pkg
// shared types and constants for the annex b nal unit locator
// ----------------------------------------------------------------------------
package anl_pkg;

   localparam int POSITION_BITS   = 32;
   localparam int OUT_BITS        = 32;
   localparam int INDEX_BITS      = 16;
   localparam int TYPE_BITS       = 5;
   localparam int BYTE_BITS       = 8;
   localparam int WINDOW_BITS     = 24;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [INDEX_BITS-1:0]  LIMIT_RESET   = INDEX_BITS'(50);
   localparam logic [BYTE_BITS-1:0]   ZERO_BYTE     = 8'h00;
   localparam logic [BYTE_BITS-1:0]   START_BYTE    = 8'h01;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET  = '1;
   localparam logic [WINDOW_BITS-1:0] SHORT_CODE    = {ZERO_BYTE, ZERO_BYTE, START_BYTE};
   localparam logic [WINDOW_BITS-1:0] LONG_PREFIX   = {ZERO_BYTE, ZERO_BYTE, ZERO_BYTE};

   // one classified byte, handed from the front to the back
   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic [TYPE_BITS-1:0]     header_type;
      logic                     code4;
      logic                     code3;
      logic                     last;
   } token_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hw/rtl/anl_front.sv -----
// ----------------------------------------------------------------------------
// anl_front
// byte window and position tracking, start code classification
// ----------------------------------------------------------------------------
module anl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [anl_pkg::BYTE_BITS-1:0] req_data_byte,
   input  logic                          req_stream_end,
   input  anl_pkg::queue_status_type     queue_status,
   output logic                          push,
   output anl_pkg::token_type            push_token
);
   import anl_pkg::*;

   logic [WINDOW_BITS-1:0]   window_ff, window_in;
   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic                     transfer;

   assign req_ready = !queue_status.full;
   assign transfer  = req_valid && req_ready;
   assign push      = transfer;

   always_comb begin
      push_token.position    = position_ff;
      push_token.header_type = req_data_byte[TYPE_BITS-1:0];
      push_token.code4       = (window_ff == LONG_PREFIX) && (req_data_byte == START_BYTE);
      push_token.code3       = (window_ff == SHORT_CODE);
      push_token.last        = req_stream_end;
   end

   always_comb begin
      window_in   = window_ff;
      position_in = position_ff;
      if (transfer) begin
         if (req_stream_end) begin
            window_in   = WINDOW_RESET;
            position_in = '0;
         end else begin
            window_in   = {window_ff[WINDOW_BITS-BYTE_BITS-1:0], req_data_byte};
            position_in = position_ff + POSITION_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= WINDOW_RESET;
         position_ff <= '0;
      end else begin
         window_ff   <= window_in;
         position_ff <= position_in;
      end
   end

endmodule

// ----- hw/rtl/anl_queue.sv -----
// ----------------------------------------------------------------------------
// anl_queue
// short token queue between the front and the back
// ----------------------------------------------------------------------------
module anl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  anl_pkg::token_type        push_token,
   input  logic                      pop,
   output anl_pkg::token_type        pop_token,
   output anl_pkg::queue_status_type status
);
   import anl_pkg::*;

   token_type                 slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_token    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hw/rtl/anl_back.sv -----
// ----------------------------------------------------------------------------
// anl_back
// unit open and close tracking, limit check and result register
// ----------------------------------------------------------------------------
module anl_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [anl_pkg::INDEX_BITS-1:0]  csr_write_data,
   input  anl_pkg::queue_status_type       queue_status,
   input  anl_pkg::token_type              pop_token,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [anl_pkg::INDEX_BITS-1:0]  rsp_unit_index,
   output logic [anl_pkg::OUT_BITS-1:0]    rsp_unit_offset,
   output logic [anl_pkg::OUT_BITS-1:0]    rsp_unit_size,
   output logic [anl_pkg::TYPE_BITS-1:0]   rsp_unit_type
);
   import anl_pkg::*;

   function automatic logic [OUT_BITS-1:0] fit_out(input logic [POSITION_BITS-1:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[OUT_BITS-1:0];
   endfunction

   logic [INDEX_BITS-1:0]    limit_ff, limit_in;
   logic                     open_ff, open_in;
   logic [POSITION_BITS-1:0] offset_ff, offset_in;
   logic [TYPE_BITS-1:0]     type_ff, type_in;
   logic [INDEX_BITS-1:0]    reported_ff, reported_in;
   logic                     pending_ff, pending_in;

   logic                     valid_ff, valid_in;
   logic [INDEX_BITS-1:0]    index_ff, index_in;
   logic [OUT_BITS-1:0]      uoffset_ff, uoffset_in;
   logic [OUT_BITS-1:0]      usize_ff, usize_in;
   logic [TYPE_BITS-1:0]     utype_ff, utype_in;

   logic [POSITION_BITS-1:0] distance;
   logic [POSITION_BITS-1:0] size;
   logic [POSITION_BITS-1:0] emit_offset;
   logic [TYPE_BITS-1:0]     emit_type;
   logic                     emit;

   assign pop = !queue_status.empty && (!valid_ff || rsp_ready);
   assign distance = pop_token.position - offset_ff;

   assign limit_in = csr_write_enable ? csr_write_data : limit_ff;

   // unit tracking for one popped token
   always_comb begin
      open_in     = open_ff;
      offset_in   = offset_ff;
      type_in     = type_ff;
      reported_in = reported_ff;
      pending_in  = pending_ff;
      emit        = 1'b0;
      size        = '0;
      emit_offset = '0;
      emit_type   = '0;
      if (pop) begin
         if (open_ff) begin
            if (distance >= POSITION_BITS'(4) && (pop_token.code4 || pop_token.code3)) begin
               emit        = 1'b1;
               size        = distance - POSITION_BITS'(3);
               emit_offset = offset_ff;
               emit_type   = type_ff;
               open_in     = 1'b0;
            end
         end else if (pending_ff && (reported_ff < limit_ff)) begin
            open_in   = 1'b1;
            offset_in = pop_token.position;
            type_in   = pop_token.header_type;
         end
         // end of stream flushes an open unit, even a single header byte
         if (pop_token.last && open_in) begin
            emit        = 1'b1;
            size        = pop_token.position + POSITION_BITS'(1) - offset_in;
            emit_offset = offset_in;
            emit_type   = type_in;
            open_in     = 1'b0;
         end
         if (emit) begin
            reported_in = reported_ff + INDEX_BITS'(1);
         end
         pending_in = pop_token.code4 && !open_in;
         if (pop_token.last) begin
            open_in     = 1'b0;
            offset_in   = '0;
            type_in     = '0;
            reported_in = '0;
            pending_in  = 1'b0;
         end
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      index_in   = index_ff;
      uoffset_in = uoffset_ff;
      usize_in   = usize_ff;
      utype_in   = utype_ff;
      if (pop && emit) begin
         valid_in   = 1'b1;
         index_in   = reported_ff;
         uoffset_in = fit_out(emit_offset);
         usize_in   = fit_out(size);
         utype_in   = emit_type;
      end else if (rsp_ready) begin
         valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= LIMIT_RESET;
         open_ff     <= 1'b0;
         offset_ff   <= '0;
         type_ff     <= '0;
         reported_ff <= '0;
         pending_ff  <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         limit_ff    <= limit_in;
         open_ff     <= open_in;
         offset_ff   <= offset_in;
         type_ff     <= type_in;
         reported_ff <= reported_in;
         pending_ff  <= pending_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff   <= index_in;
      uoffset_ff <= uoffset_in;
      usize_ff   <= usize_in;
      utype_ff   <= utype_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_unit_index  = index_ff;
   assign rsp_unit_offset = uoffset_ff;
   assign rsp_unit_size   = usize_ff;
   assign rsp_unit_type   = utype_ff;

endmodule

// ----- hw/rtl/annexb_nal_unit_locator.sv -----
// ----------------------------------------------------------------------------
// annexb_nal_unit_locator
// annex b start code scanner reporting index, offset, size and type per unit
// ----------------------------------------------------------------------------
// the closing byte's token passes the queue before rsp_valid is registered
// throughput: one byte per cycle while the queue has room, set by the
//   combinational window compare in the front and unit update in the back
// a four-entry token queue absorbs result stalls before req_ready drops
// reset: synchronous, sets the window to all ones, clears position, unit
//   state and queue, and returns unit_limit to 50
module annexb_nal_unit_locator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [anl_pkg::BYTE_BITS-1:0]   req_data_byte,
   input  logic                            req_stream_end,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [anl_pkg::INDEX_BITS-1:0]  rsp_unit_index,
   output logic [anl_pkg::OUT_BITS-1:0]    rsp_unit_offset,
   output logic [anl_pkg::OUT_BITS-1:0]    rsp_unit_size,
   output logic [anl_pkg::TYPE_BITS-1:0]   rsp_unit_type,
   input  logic                            csr_write_enable,
   input  logic [anl_pkg::INDEX_BITS-1:0]  csr_write_data
);
   import anl_pkg::*;

   // classified bytes flow front -> queue -> back
   queue_status_type queue_status;
   token_type        push_token;
   token_type        pop_token;
   logic             push;
   logic             pop;

   // front: keeps the last three bytes and the byte position, flags codes
   anl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_stream_end (req_stream_end),
      .queue_status   (queue_status),
      .push           (push),
      .push_token     (push_token)
   );

   // queue: lets the front keep taking bytes while a result waits
   anl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .pop_token  (pop_token),
      .status     (queue_status)
   );

   // back: opens and closes units, holds the limit, drives the result register
   anl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_status     (queue_status),
      .pop_token        (pop_token),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_unit_index   (rsp_unit_index),
      .rsp_unit_offset  (rsp_unit_offset),
      .rsp_unit_size    (rsp_unit_size),
      .rsp_unit_type    (rsp_unit_type)
   );

endmodule

// ----- hw/rtl/anl_checker.sv -----
// ----------------------------------------------------------------------------
// anl_checker
// port-level checks for the nal unit locator, bound to the top level
// ----------------------------------------------------------------------------
module anl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [anl_pkg::INDEX_BITS-1:0]  rsp_unit_index,
   input logic [anl_pkg::OUT_BITS-1:0]    rsp_unit_offset,
   input logic [anl_pkg::OUT_BITS-1:0]    rsp_unit_size,
   input logic [anl_pkg::TYPE_BITS-1:0]   rsp_unit_type
);
   import anl_pkg::*;

   logic seen_ff, seen_in;

   assign seen_in = seen_ff || (req_valid && req_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_unit_index)
         && $stable(rsp_unit_offset) && $stable(rsp_unit_size) && $stable(rsp_unit_type))
      else $error("result changed while stalled");

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a result needs an earlier byte transfer
   assert property (@(posedge clock) disable iff (reset) $rose(rsp_valid) |-> seen_ff)
      else $error("result without any byte transfer");

endmodule

bind annexb_nal_unit_locator anl_checker u_anl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_unit_index  (rsp_unit_index),
   .rsp_unit_offset (rsp_unit_offset),
   .rsp_unit_size   (rsp_unit_size),
   .rsp_unit_type   (rsp_unit_type)
);
